// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ===== design/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, register indexes and the byte folding function of the
// caseless substring finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csf_pkg;

    typedef logic [7:0] t_byte;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_BYTES  = 2'd0;
    localparam t_cfg_idx CFG_PATTERN_LENGTH = 2'd1;

    // Width of the pattern register in bytes and of the length register
    localparam int PAT_BYTES = 8;
    localparam int LEN_W     = 4;
    localparam int POS_OUT_W = 16;

    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [POS_OUT_W-1:0] t_pos;

    // One result beat
    typedef struct packed {
        logic found;
        t_pos match_position;
    } t_result;

    // Control handed to every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

    // Fold A-Z to lower case, pass everything else
    function automatic t_byte fold_byte(input t_byte b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

endpackage

// ===== design/csf_ifs.sv =====
// ----------------------------------------------------------------------------
// csf_ifs
// Valid/ready channels of the caseless substring finder: text in, result
// out and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface csf_text_if;
    logic           valid;
    logic           ready;
    csf_pkg::t_byte text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface csf_result_if;
    logic           valid;
    logic           ready;
    logic           found;
    csf_pkg::t_pos  match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface csf_cfg_if;
    logic              valid;
    logic              ready;
    csf_pkg::t_cfg_idx index;
    logic [63:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/csf_cell.sv =====
// ----------------------------------------------------------------------------
// csf_cell
// One window cell: holds one folded text byte, hands it to the next cell on
// every beat and compares it with the pattern byte aligned to its place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csf_pkg::t_cell_ctl  i_ctl,
    input  csf_pkg::t_byte      i_byte,
    input  csf_pkg::t_byte      i_pat,
    input  logic                i_use,
    output csf_pkg::t_byte      o_byte,
    output logic                o_ok
);
    import csf_pkg::*;

    t_byte r_byte;

    // Shift in the neighbor's byte, drop the window at string end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_ctl.clear ? '0 : i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = !i_use || (r_byte == i_pat);

endmodule

// ===== design/csf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// csf_out_fifo
// Two-entry circular result buffer, so the
// text side keeps moving while a result waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csf_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csf_pkg::t_result  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output csf_pkg::t_result  o_data
);
    import csf_pkg::*;

    localparam int DEPTH = 2;

    t_result    r_mem [0:DEPTH-1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && i_ready;

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/caseless_substring_finder_top.sv =====
// ----------------------------------------------------------------------------
// caseless_substring_finder_top
// Case-insensitive search of a short pattern in zero-terminated text
// arriving one byte per beat, built as a shifting row of compare cells.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          notes
//  i_text    in   text_byte[7:0]                   zero byte ends the string
//  o_result  out  found, match_position[15:0]      at most one per text beat
//  i_cfg     in   index[1:0], data[63:0]           always ready
//
//  One text beat per cycle while the result buffer has room; a result is
//  registered in the result buffer before it leaves. The row of window cells
//  moves every beat; all cells compare in the same cycle the byte arrives.
//  Reset clears the window, the count, the registers and the result buffer.
//  i_text.ready drops only when both result buffer entries are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caseless_substring_finder_top #(
    parameter int MAX_PATTERN   = 8,
    parameter int POSITION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csf_text_if.sink     i_text,
    csf_result_if.source o_result,
    csf_cfg_if.sink      i_cfg
);
    import csf_pkg::*;

    localparam int   POS_EXT_W  = (POSITION_BITS > POS_OUT_W) ? POSITION_BITS : POS_OUT_W;
    localparam t_len MAX_LEN    = LEN_W'(MAX_PATTERN);

    logic [63:0]              r_pattern_bytes;
    t_len                     r_pattern_length;
    logic [POSITION_BITS-1:0] r_bytes_seen;
    logic                     r_reported;

    t_byte      w_c;
    logic       w_accept;
    logic       w_zero;
    t_byte      w_pat_raw  [0:PAT_BYTES-1];
    t_byte      w_pat_fold [0:PAT_BYTES-1];
    t_len       w_len;
    t_byte      w_q   [0:MAX_PATTERN-1];
    logic       w_use [0:MAX_PATTERN-1];
    t_byte      w_win [0:MAX_PATTERN-1];
    logic [MAX_PATTERN-1:0] w_ok;
    logic       w_hit;
    logic       w_produced;
    logic       w_full;
    t_cell_ctl  w_ctl;
    t_result    w_result;
    t_result    w_out;
    logic [POSITION_BITS-1:0] w_pos;
    logic [POS_EXT_W-1:0]     w_pos_ext;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PATTERN_BYTES:  r_pattern_bytes  <= i_cfg.data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Split and fold the pattern
    always_comb begin
        for (int k = 0; k < PAT_BYTES; k++) begin
            w_pat_raw[k]  = r_pattern_bytes[8*k +: 8];
            w_pat_fold[k] = fold_byte(r_pattern_bytes[8*k +: 8]);
        end
    end

    // Effective length: clamp, then stop at the first zero pattern byte
    always_comb begin
        t_len lim;
        logic stop;
        lim  = (r_pattern_length > MAX_LEN) ? MAX_LEN : r_pattern_length;
        w_len = lim;
        stop = 1'b0;
        for (int k = 0; k < PAT_BYTES; k++) begin
            if (!stop && (LEN_W'(k) < lim) && (w_pat_raw[k] == 8'h00)) begin
                w_len = LEN_W'(k);
                stop  = 1'b1;
            end
        end
    end

    // Align the pattern so that place b holds the byte expected b beats back
    always_comb begin
        t_len diff;
        for (int b = 0; b < MAX_PATTERN; b++) begin
            diff     = w_len - LEN_W'(b) - 4'd1;
            w_use[b] = (LEN_W'(b) < w_len);
            w_q[b]   = w_pat_fold[diff[2:0]];
        end
    end

    // Current byte is place zero of the row
    assign w_accept = i_text.valid && i_text.ready;
    assign w_c      = fold_byte(i_text.text_byte);
    assign w_zero   = (w_c == 8'h00);
    assign w_win[0] = w_c;
    assign w_ok[0]  = !w_use[0] || (w_c == w_q[0]);

    assign w_ctl.shift = w_accept;
    assign w_ctl.clear = w_zero;

    // Row of window cells, each one byte further back
    for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_cell
        csf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (w_win[j-1]),
            .i_pat   (w_q[j]),
            .i_use   (w_use[j]),
            .o_byte  (w_win[j]),
            .o_ok    (w_ok[j])
        );
    end

    // Match decision and start position
    assign w_hit = (w_len != '0) && !w_zero && (&w_ok)
                && (r_bytes_seen >= POSITION_BITS'(w_len - 4'd1));
    assign w_pos     = r_bytes_seen - POSITION_BITS'(w_len - 4'd1);
    assign w_pos_ext = POS_EXT_W'(w_pos);

    always_comb begin
        w_result.found          = (w_len == '0) || w_hit;
        w_result.match_position = '0;
        if (w_len != '0 && w_hit) begin
            w_result.match_position = (w_pos_ext > POS_EXT_W'(16'hFFFF)) ? 16'hFFFF
                                    : w_pos_ext[POS_OUT_W-1:0];
        end
    end

    assign w_produced = w_accept && !r_reported && ((w_len == '0) || w_hit || w_zero);

    // Per-string count and report flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
        end else if (w_accept) begin
            if (w_zero) begin
                r_bytes_seen <= '0;
                r_reported   <= 1'b0;
            end else begin
                if (r_bytes_seen != '1) begin
                    r_bytes_seen <= r_bytes_seen + 1'b1;
                end
                if (w_produced) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    // Result buffer
    csf_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_produced),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (w_out)
    );

    assign i_text.ready            = !w_full;
    assign o_result.found          = w_out.found;
    assign o_result.match_position = w_out.match_position;

endmodule

// ===== design/csf_checker.sv =====
// ----------------------------------------------------------------------------
// csf_port_checker
// Port-level checks of the caseless substring finder, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csf_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_text_valid,
    input logic        i_text_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_res_found,
    input logic [15:0] i_res_pos
);

    logic [16:0] w_payload;

    assign w_payload = {i_res_found, i_res_pos};

    // Hold a stalled result beat
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // Keep the payload of a stalled result beat
    `ASSERT_NEXT(a_res_stable, i_clk, i_rst_n, i_res_valid && !i_res_ready, $stable(w_payload))

    // A result only appears after a text beat was taken
    `ASSERT_NOW(a_res_cause, i_clk, i_rst_n, $rose(i_res_valid), $past(i_text_valid && i_text_ready))

    // A miss always carries position zero
    `ASSERT_NOW(a_miss_pos, i_clk, i_rst_n, i_res_valid && !i_res_found, i_res_pos == 16'h0000)

endmodule

bind caseless_substring_finder_top csf_port_checker u_csf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_text_valid (i_text.valid),
    .i_text_ready (i_text.ready),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_found  (o_result.found),
    .i_res_pos    (o_result.match_position)
);
